@@ rtl/core/dsv_pkg.sv @@
// Shared types, character codes and calendar helpers for the date string validator.
// No dependencies; imported by dsv_core and date_string_validator.
`default_nettype none

package dsv_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Field phase codes
    localparam logic [1:0] PH_DAY   = 2'd0;
    localparam logic [1:0] PH_MONTH = 2'd1;
    localparam logic [1:0] PH_YEAR  = 2'd2;

    localparam logic [2:0]  DC_MAX      = 3'd7;
    localparam logic [2:0]  DM_LIMIT    = 3'd2;
    localparam logic [2:0]  YEAR_LIMIT  = 3'd4;
    localparam logic [13:0] YEAR_BASE   = 14'd2000;
    localparam logic [3:0]  MONTH_LAST  = 4'd12;

    typedef struct packed {
        logic        valid_res;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } dsv_res_t;

    // Two-digit value tens*10+units is divisible by 4 iff (2*tens+units) mod 4 == 0
    function automatic logic div4_2dig(input logic [3:0] tens, input logic [3:0] units);
        logic [1:0] s;
        s = {tens[0], 1'b0} + units[1:0];
        return (s == 2'd0);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/date_string_validator.sv @@
// Date string validator: one character per cycle, one result per NUL terminator.
// A terminator's result passes through the input register, then the result register.
// Throughput: one character per cycle while no terminator waits.
// A terminator waits in the input register while an earlier result is still unaccepted.
// Reset (rst_n low, asynchronous): parser back in the day field, all empty.
// Instantiates dsv_core; uses dsv_pkg.
`default_nettype none

module date_string_validator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // character channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             valid_res,
    output logic [4:0]       day,
    output logic [3:0]       month,
    output logic [13:0]      year
);
    import dsv_pkg::*;

    // Input register: holds one character until the parser steps on it.
    logic       s1_valid_reg;
    logic [7:0] ch_reg;

    // Result register
    logic       out_valid_reg;
    dsv_res_t   res_reg;
    dsv_res_t   res;

    logic out_free;
    logic s1_fire;
    logic in_fire;
    logic s1_term;

    // A non-terminator never produces an item, so it steps even while a result waits.
    // Only a terminator needs room in the result register.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_term  = (ch_reg == CH_NUL);
    assign s1_fire  = s1_valid_reg && (!s1_term || out_free);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg <= ch;
        end
    end

    dsv_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_fire),
        .ch    (ch_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_term)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_term)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = res_reg.valid_res;
    assign day       = res_reg.day;
    assign month     = res_reg.month;
    assign year      = res_reg.year;

    // A new result item only follows a terminator stepped in the previous cycle.
    a_rise_from_term: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire && s1_term))
        else $error("result item without a terminator");

    // A valid date carries a day and month in range.
    a_valid_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |->
            (day != 5'd0) && (month != 4'd0) && (month <= MONTH_LAST))
        else $error("valid result with out-of-range day or month");

    // An invalid date carries zero fields.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (day == 5'd0) && (month == 4'd0) && (year == 14'd0))
        else $error("invalid result with nonzero fields");

    // A held character in the input register is not lost while the parser waits.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(ch_reg)))
        else $error("stalled input item changed");

endmodule

`default_nettype wire

@@ rtl/core/dsv_core.sv @@
// Parser state for the date string validator: field phase, digit counts, accumulators.
// Updates on each stepped character; builds the result for a terminator. Uses dsv_pkg.
`default_nettype none

module dsv_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      ch,
    output dsv_pkg::dsv_res_t    res
);
    import dsv_pkg::*;

    logic [1:0]  phase_reg,  phase_next;
    logic [2:0]  dc_reg,     dc_next;
    logic [6:0]  day_reg,    day_next;
    logic [6:0]  month_reg,  month_next;
    logic [13:0] year_reg,   year_next;
    logic        err_reg,    err_next;
    // last four year digits, oldest first; zeros stay in the high places for short years
    logic [3:0]  yd_reg [4];
    logic [3:0]  yd_next [4];

    logic [3:0] digit;
    logic       is_digit;
    logic [2:0] limit;

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit    = ch[3:0];
    assign limit    = (phase_reg == PH_YEAR) ? YEAR_LIMIT : DM_LIMIT;

    always_comb
    begin
        phase_next = phase_reg;
        dc_next    = dc_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        err_next   = err_reg;
        for (int i = 0; i < 4; i++)
        begin
            yd_next[i] = yd_reg[i];
        end
        if (ch == CH_NUL)
        begin
            phase_next = PH_DAY;
            dc_next    = 3'd0;
            day_next   = 7'd0;
            month_next = 7'd0;
            year_next  = 14'd0;
            err_next   = 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                yd_next[i] = 4'd0;
            end
        end
        else if (ch == CH_SLASH)
        begin
            if (phase_reg == PH_YEAR)
            begin
                err_next = 1'b1;
            end
            else
            begin
                if (dc_reg < 3'd1 || dc_reg > DM_LIMIT)
                begin
                    err_next = 1'b1;
                end
                phase_next = (phase_reg == PH_DAY) ? PH_MONTH : PH_YEAR;
                dc_next    = 3'd0;
            end
        end
        else if (is_digit)
        begin
            if (dc_reg >= limit)
            begin
                err_next = 1'b1;
            end
            else if (phase_reg == PH_DAY)
            begin
                day_next = (day_reg << 3) + (day_reg << 1) + {3'd0, digit};
            end
            else if (phase_reg == PH_MONTH)
            begin
                month_next = (month_reg << 3) + (month_reg << 1) + {3'd0, digit};
            end
            else
            begin
                year_next  = (year_reg << 3) + (year_reg << 1) + {10'd0, digit};
                yd_next[0] = yd_reg[1];
                yd_next[1] = yd_reg[2];
                yd_next[2] = yd_reg[3];
                yd_next[3] = digit;
            end
            if (dc_reg < DC_MAX)
            begin
                dc_next = dc_reg + 3'd1;
            end
        end
        else
        begin
            err_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DAY;
            dc_reg    <= 3'd0;
            day_reg   <= 7'd0;
            month_reg <= 7'd0;
            year_reg  <= 14'd0;
            err_reg   <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                yd_reg[i] <= 4'd0;
            end
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            dc_reg    <= dc_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            err_reg   <= err_next;
            for (int i = 0; i < 4; i++)
            begin
                yd_reg[i] <= yd_next[i];
            end
        end
    end

    // Terminator result. Short years get 2000 added; the high digit pair then reads 00,
    // which leaves the leap test unchanged since 2000 is a multiple of 400.
    logic        short_year;
    logic        len_ok;
    logic        leap;
    logic        low_zero;
    logic [4:0]  mlen;
    logic [13:0] year_full;
    logic        ok;

    assign short_year = (dc_reg == 3'd1) || (dc_reg == 3'd2);
    assign len_ok     = short_year || (dc_reg == YEAR_LIMIT);
    assign low_zero   = (yd_reg[2] == 4'd0) && (yd_reg[3] == 4'd0);
    assign leap       = div4_2dig(yd_reg[2], yd_reg[3]) &&
                        (!low_zero || div4_2dig(yd_reg[0], yd_reg[1]));
    assign mlen       = month_len(month_reg[3:0], leap);
    assign year_full  = short_year ? (year_reg + YEAR_BASE) : year_reg;

    assign ok = !err_reg && (phase_reg == PH_YEAR) && len_ok &&
                (month_reg >= 7'd1) && (month_reg <= {3'd0, MONTH_LAST}) &&
                (day_reg >= 7'd1) && (day_reg <= {2'd0, mlen});

    always_comb
    begin
        res.valid_res = ok;
        res.day       = ok ? day_reg[4:0]   : 5'd0;
        res.month     = ok ? month_reg[3:0] : 4'd0;
        res.year      = ok ? year_full      : 14'd0;
    end

endmodule

`default_nettype wire
